FILE: hw/rtl/xor_sprite_framebuffer_assert.svh
// assertion macros for the xor sprite framebuffer rtl
// included by the modules that carry concurrent checks; no other dependencies
`ifndef XOR_SPRITE_FRAMEBUFFER_ASSERT_SVH
`define XOR_SPRITE_FRAMEBUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define XSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsf same-cycle check failed");
// next-cycle implication, disabled during reset
`define XSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xsf next-cycle check failed");
`else
`define XSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define XSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/xsf_pkg.sv
// shared types and op codes for the xor sprite framebuffer
// no dependencies; imported by xsf_if, xsf_ctrl, xsf_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package xsf_pkg;

    // op codes of an input item
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int ROW_BITS_W = 64;
    localparam int SPRITE_W   = 8;

    // input item payload
    typedef struct packed {
        logic [1:0]            op;
        logic [7:0]            x_pos;
        logic [7:0]            y_pos;
        logic [3:0]            row_index;
        logic [SPRITE_W-1:0]   sprite_byte;
        logic                  last_row;
    } item_in_t;

    // result item payload
    typedef struct packed {
        logic                  collision;
        logic [ROW_BITS_W-1:0] row_bits;
        logic                  sprite_done;
    } item_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc;
        logic rd_en;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xsf_if.sv
// valid/ready channel interfaces for input and result items
// depends on xsf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface xsf_in_if;
    import xsf_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [7:0]          x_pos;
    logic [7:0]          y_pos;
    logic [3:0]          row_index;
    logic [SPRITE_W-1:0] sprite_byte;
    logic                last_row;

    modport source (
        output valid, op, x_pos, y_pos, row_index, sprite_byte, last_row,
        input  ready
    );
    modport sink (
        input  valid, op, x_pos, y_pos, row_index, sprite_byte, last_row,
        output ready
    );
endinterface

interface xsf_out_if;
    import xsf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  collision;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  sprite_done;

    modport source (
        output valid, collision, row_bits, sprite_done,
        input  ready
    );
    modport sink (
        input  valid, collision, row_bits, sprite_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/xsf_ram.sv
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module xsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     rd_en,
    input  wire logic                     wr_en,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/xsf_ctrl.sv
// controller state machine: sequences capture, reduce, read and write back
// depends on xsf_pkg and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "xor_sprite_framebuffer_assert.svh"

module xsf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output xsf_pkg::ctl_cmd_t      cmd,
    input  wire xsf_pkg::ctl_sts_t sts
);
    import xsf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:  state_next = S_READ;
            S_READ:  state_next = S_WRITE;
            S_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.calc    = (state_reg == S_CALC);
        cmd.rd_en   = (state_reg == S_READ);
        cmd.finish  = (state_reg == S_WRITE) && sts.out_free;
    end

    `XSF_ASSERT_NEXT(a_calc_then_read, clk, rst_n, state_reg == S_CALC, state_reg == S_READ)
    `XSF_ASSERT_NEXT(a_read_then_write, clk, rst_n, state_reg == S_READ, state_reg == S_WRITE)
    `XSF_ASSERT_NEXT(a_write_holds_stall, clk, rst_n, state_reg == S_WRITE && !sts.out_free, state_reg == S_WRITE)

endmodule

`default_nettype wire

FILE: hw/rtl/xsf_datapath.sv
// datapath: row/column reduction, sprite rotate, read-modify-write, result register
// depends on xsf_pkg, xsf_ram and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "xor_sprite_framebuffer_assert.svh"

module xsf_datapath #(
    parameter int SCREEN_ROWS = 32,
    parameter int SCREEN_COLS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire xsf_pkg::ctl_cmd_t  cmd,
    output xsf_pkg::ctl_sts_t       sts,
    input  wire xsf_pkg::item_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output xsf_pkg::item_out_t      out_data
);
    import xsf_pkg::*;

    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CW = $clog2(SCREEN_COLS);
    localparam logic [8:0] ROWS_D = 9'(SCREEN_ROWS);
    localparam logic [8:0] COLS_D = 9'(SCREEN_COLS);

    // fixed-point reciprocals of the screen sizes, exact quotient for 9-bit values
    localparam int          RECIP_SH = 18;
    localparam logic [17:0] ROWS_M   = 18'((2**RECIP_SH + SCREEN_ROWS - 1) / SCREEN_ROWS);
    localparam logic [17:0] COLS_M   = 18'((2**RECIP_SH + SCREEN_COLS - 1) / SCREEN_COLS);

    // remainder by reciprocal multiply, then one multiply-back and subtract
    function automatic logic [8:0] reduce9(input logic [8:0] v, input logic [8:0] d,
                                           input logic [17:0] m);
        logic [26:0] prod;
        logic [8:0]  q;
        logic [17:0] qd;
        prod = {18'b0, v} * {9'b0, m};
        q    = prod[26:18];
        qd   = {9'b0, q} * {9'b0, d};
        return v - qd[8:0];
    endfunction

    item_in_t               in_reg;
    logic [RW-1:0]          addr_reg;
    logic [CW-1:0]          col_reg;
    logic [SCREEN_COLS-1:0] placed_reg;
    logic [SCREEN_ROWS-1:0] valid_reg;
    logic                   seen_reg;
    logic                   out_valid_reg;
    item_out_t              out_reg;

    logic [8:0]             row_sel;
    logic [SCREEN_COLS-1:0] base;
    logic [2*SCREEN_COLS-1:0] doubled;
    logic [SCREEN_COLS-1:0] rdata;
    logic [SCREEN_COLS-1:0] old_row;
    logic [SCREEN_COLS-1:0] new_row;
    logic                   collided;
    logic                   seen_next;
    logic                   is_draw;
    logic                   is_read;
    logic                   is_clear;

    assign is_draw  = (in_reg.op == OP_DRAW);
    assign is_read  = (in_reg.op == OP_READ);
    assign is_clear = (in_reg.op == OP_CLEAR);

    // target row before wrapping: the sum of y and row index for a draw, y otherwise
    assign row_sel = is_draw ? ({1'b0, in_reg.y_pos} + {5'b0, in_reg.row_index})
                             : {1'b0, in_reg.y_pos};

    // sprite placed at the left edge, then rotated right by the column
    assign base    = SCREEN_COLS'(in_reg.sprite_byte) << (SCREEN_COLS - SPRITE_W);
    assign doubled = {base, base} >> col_reg;

    // input item capture, then address and column reduction, then placed row
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.calc)
        begin
            addr_reg <= RW'(reduce9(row_sel, ROWS_D, ROWS_M));
            col_reg  <= CW'(reduce9({1'b0, in_reg.x_pos}, COLS_D, COLS_M));
        end
        if (cmd.rd_en)
        begin
            placed_reg <= doubled[SCREEN_COLS-1:0];
        end
    end

    xsf_ram #(
        .WIDTH (SCREEN_COLS),
        .DEPTH (SCREEN_ROWS)
    ) u_frame_ram (
        .clk   (clk),
        .addr  (addr_reg),
        .rd_en (cmd.rd_en),
        .wr_en (cmd.finish && is_draw),
        .wdata (new_row),
        .rdata (rdata)
    );

    // rows never written since the last clear read as zero
    assign old_row   = valid_reg[addr_reg] ? rdata : '0;
    assign new_row   = old_row ^ placed_reg;
    assign collided  = |(old_row & placed_reg);
    assign seen_next = ((in_reg.row_index == 4'd0) ? 1'b0 : seen_reg) | collided;

    // row valid bits and collision flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (is_clear)
            begin
                valid_reg <= '0;
            end
            else if (is_draw)
            begin
                valid_reg[addr_reg] <= 1'b1;
                seen_reg            <= seen_next;
            end
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.collision   <= is_draw && seen_next;
            out_reg.sprite_done <= is_draw && in_reg.last_row;
            if (is_draw)
            begin
                out_reg.row_bits <= ROW_BITS_W'(new_row);
            end
            else if (is_read)
            begin
                out_reg.row_bits <= ROW_BITS_W'(old_row);
            end
            else
            begin
                out_reg.row_bits <= '0;
            end
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    `XSF_ASSERT_NEXT(a_finish_loads_result, clk, rst_n, cmd.finish, out_valid_reg)
    `XSF_ASSERT_NEXT(a_clear_drops_rows, clk, rst_n, cmd.finish && is_clear, valid_reg == '0)
    `XSF_ASSERT_NEXT(a_draw_marks_row, clk, rst_n, cmd.finish && is_draw, valid_reg[$past(addr_reg)])

endmodule

`default_nettype wire

FILE: hw/rtl/xor_sprite_framebuffer.sv
// top level of the xor sprite framebuffer: controller, datapath and channel glue
// depends on xsf_pkg, xsf_if, xsf_ctrl and xsf_datapath
`timescale 1ns / 1ps
`default_nettype none

// Monochrome framebuffer of SCREEN_ROWS rows by SCREEN_COLS pixels, leftmost pixel
// in the top bit of a row. Every input item gives exactly one result item: a draw
// XORs an 8-pixel sprite row into row (y_pos + row_index) mod SCREEN_ROWS, rotated
// right to column x_pos mod SCREEN_COLS, and returns the new row with the collision
// flag (restarted on row_index 0) and sprite_done; a read returns row y_pos mod
// SCREEN_ROWS; a clear zeroes the screen by dropping the per-row valid bits, so
// no clearing pass follows reset. Each item passes in order through the accept in
// idle, a step to reduce row and column, one read of the single-port frame ram and
// a step to modify and write the row back; a new item is accepted only once that
// read-modify-write on one ram port is done. A finished result sits in an output
// register, and the write-back waits only while the previous result is untaken.
module xor_sprite_framebuffer #(
    parameter int SCREEN_ROWS = 32,
    parameter int SCREEN_COLS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    xsf_in_if.sink    in_item,
    xsf_out_if.source out_item
);
    import xsf_pkg::*;

    ctl_cmd_t  cmd;
    ctl_sts_t  sts;
    item_in_t  in_data;
    item_out_t out_data;
    logic      out_valid;

    // pack the input channel payload
    always_comb
    begin
        in_data.op          = in_item.op;
        in_data.x_pos       = in_item.x_pos;
        in_data.y_pos       = in_item.y_pos;
        in_data.row_index   = in_item.row_index;
        in_data.sprite_byte = in_item.sprite_byte;
        in_data.last_row    = in_item.last_row;
    end

    xsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    xsf_datapath #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_item.ready),
        .out_data  (out_data)
    );

    // drive the result channel
    assign out_item.valid       = out_valid;
    assign out_item.collision   = out_data.collision;
    assign out_item.row_bits    = out_data.row_bits;
    assign out_item.sprite_done = out_data.sprite_done;

endmodule

`default_nettype wire
